// File: rtl/alg_pkg.sv
// Package for the autostereogram line generator.
// Holds sizes, register indexes, reset values and shared types.
// No dependencies.
`default_nettype none

package alg_pkg;

    localparam int MAX_ROW_WIDTH  = 1024;
    localparam int MAX_BAND_WIDTH = 256;

    localparam int COL_W     = $clog2(MAX_ROW_WIDTH);
    localparam int PAT_W     = $clog2(MAX_BAND_WIDTH);
    localparam int ROW_W     = 11;
    localparam int BAND_W    = 9;
    localparam int GAIN_W    = 4;
    localparam int LEVELS_W  = 9;
    localparam int DEPTH_W   = 8;
    localparam int PIDX_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int IN_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_NEGATIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_WAY_DEPTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LEVELS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_OUTPUT = 3'd7;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [ROW_W-1:0]    RST_ROW_WIDTH    = 11'd640;
    localparam logic [BAND_W-1:0]   RST_BAND_WIDTH   = 9'd106;
    localparam logic [GAIN_W-1:0]   RST_DEPTH_GAIN   = 4'd1;
    localparam logic [LEVELS_W-1:0] RST_DEPTH_LEVELS = 9'd256;

    typedef struct packed {
        logic [ROW_W-1:0]    row_width;
        logic [BAND_W-1:0]   band_width;
        logic [GAIN_W-1:0]   depth_gain;
        logic                invert_mode;
        logic                wrap_negative;
        logic                one_way_depth;
        logic [LEVELS_W-1:0] depth_levels;
        logic                invert_output;
    } cfg_t;

    typedef struct packed {
        logic             use_line;
        logic [PAT_W-1:0] pat_idx;
        logic [COL_W-1:0] line_idx;
    } src_sel_t;

endpackage

`default_nettype wire

// File: rtl/alg_src_calc.sv
// Shift computation and source selection for one output column.
// Turns a depth sample into a clamped shift and picks a pattern or line entry.
// Depends on alg_pkg.
`default_nettype none

module alg_src_calc (
    input  wire alg_pkg::cfg_t                   cfg,
    input  wire logic [alg_pkg::COL_W-1:0]       col,
    input  wire logic [alg_pkg::DEPTH_W-1:0]     depth_value,
    output alg_pkg::src_sel_t                    src
);
    import alg_pkg::*;

    localparam int HW  = DEPTH_W + 3;
    localparam int MW  = HW + GAIN_W + 1;
    localparam int SW  = ((MW > COL_W + 1) ? MW : COL_W + 1) + 1;
    localparam int BEW = $clog2(MAX_BAND_WIDTH + 1);

    logic signed [HW-1:0] h_inv;
    logic signed [HW-1:0] h_wrap;
    logic signed [MW-1:0] h_mul;
    logic signed [MW-1:0] band_m1;
    logic signed [MW-1:0] h_cl;
    logic [BEW-1:0]       band_eff;
    logic signed [SW-1:0] band_s;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] line_d;

    always_comb
    begin
        if (cfg.band_width == '0)
        begin
            band_eff = BEW'(1);
        end
        else if ({{(32-BAND_W){1'b0}}, cfg.band_width} > MAX_BAND_WIDTH)
        begin
            band_eff = BEW'(MAX_BAND_WIDTH);
        end
        else
        begin
            band_eff = BEW'(cfg.band_width);
        end

        h_inv = $signed({{(HW-DEPTH_W){1'b0}}, depth_value});
        if (cfg.invert_mode)
        begin
            h_inv = -h_inv;
        end

        h_wrap = h_inv;
        if (cfg.wrap_negative &&
            (h_inv > $signed({{(HW-LEVELS_W+1){1'b0}}, cfg.depth_levels[LEVELS_W-1:1]})))
        begin
            h_wrap = h_inv - $signed({{(HW-LEVELS_W){1'b0}}, cfg.depth_levels});
        end

        h_mul   = MW'(h_wrap) * $signed({{(MW-GAIN_W){1'b0}}, cfg.depth_gain});
        band_m1 = $signed({{(MW-BEW){1'b0}}, band_eff}) - MW'(1);

        priority if (cfg.one_way_depth && (h_mul < 0))
        begin
            h_cl = band_m1;
        end
        else if (h_mul > band_m1)
        begin
            h_cl = band_m1;
        end
        else
        begin
            h_cl = h_mul;
        end

        band_s = $signed({{(SW-BEW){1'b0}}, band_eff});
        sum    = $signed({{(SW-COL_W){1'b0}}, col}) + SW'(h_cl);
        line_d = sum - band_s;

        src.use_line = !(sum < band_s);
        src.pat_idx  = (sum < 0) ? '0 : sum[PAT_W-1:0];
        src.line_idx = line_d[COL_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/autostereogram_line_generator_core.sv
// Autostereogram line generator top level: pattern store, line store, packing.
// Depends on alg_pkg and alg_src_calc.
//
// Channel   Dir  Fields (low bit up)
// s_axis    in   tuser: action; tdata: pattern_index, pattern_pixel, depth_value
// m_axis    out  tdata: packed_byte; tlast: row_end
// cfg       in   cfg_we, cfg_index, cfg_wdata (no read-back)
//
// One item per cycle; input stalls only when a byte waits on m_axis and
// another is due. A pixel item reads the pattern or line store at acceptance
// and writes the line store as it leaves s1; a one-entry write forward covers
// a read of the column just written. A byte is registered for m_axis as its
// closing column leaves s1. Reset clears the column counter, valid flags,
// accumulator and configuration; store contents stay undefined until written.
`default_nettype none

module autostereogram_line_generator_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] pattern_index, [8] pattern_pixel, [16:9] depth_value, [23:17] zero
    input  wire logic [alg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] action
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] packed_byte
    output logic [alg_pkg::BYTE_W-1:0]           m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [alg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [alg_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
    import alg_pkg::*;

    cfg_t     cfg_reg;
    src_sel_t src;

    logic [PIDX_W-1:0]  in_pat_idx;
    logic               in_pat_pix;
    logic [DEPTH_W-1:0] in_depth;
    logic               accept;
    logic               pix_acc;
    logic               load_acc;

    logic [ROW_W-1:0]   row_eff;
    logic               end_now;
    logic               emit_now;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_use_line_reg;
    logic [COL_W-1:0]   s1_line_idx_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_emit_reg;
    logic               s1_end_reg;
    logic               s1_fire;

    logic               pat_mem [MAX_BAND_WIDTH];
    logic               line_mem [MAX_ROW_WIDTH];
    logic               pat_rd_reg;
    logic               line_rd_reg;

    logic               lw_valid_reg;
    logic [COL_W-1:0]   lw_addr_reg;
    logic               lw_data_reg;

    logic               pix;
    logic [BYTE_W-1:0]  acc_reg;
    logic [BYTE_W-1:0]  acc_set;
    logic [BYTE_W-1:0]  acc_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;

    assign in_pat_idx = s_axis_tdata[PIDX_W-1:0];
    assign in_pat_pix = s_axis_tdata[PIDX_W];
    assign in_depth   = s_axis_tdata[PIDX_W+DEPTH_W:PIDX_W+1];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign pix_acc  = accept && (s_axis_tuser == ACT_PIXEL);
    assign load_acc = accept && (s_axis_tuser == ACT_LOAD);

    alg_src_calc u_src_calc (
        .cfg         (cfg_reg),
        .col         (col_reg),
        .depth_value (in_depth),
        .src         (src)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width     <= RST_ROW_WIDTH;
            cfg_reg.band_width    <= RST_BAND_WIDTH;
            cfg_reg.depth_gain    <= RST_DEPTH_GAIN;
            cfg_reg.invert_mode   <= 1'b0;
            cfg_reg.wrap_negative <= 1'b0;
            cfg_reg.one_way_depth <= 1'b0;
            cfg_reg.depth_levels  <= RST_DEPTH_LEVELS;
            cfg_reg.invert_output <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH:     cfg_reg.row_width     <= cfg_wdata[ROW_W-1:0];
                REG_BAND_WIDTH:    cfg_reg.band_width    <= cfg_wdata[BAND_W-1:0];
                REG_DEPTH_GAIN:    cfg_reg.depth_gain    <= cfg_wdata[GAIN_W-1:0];
                REG_INVERT_MODE:   cfg_reg.invert_mode   <= cfg_wdata[0];
                REG_WRAP_NEGATIVE: cfg_reg.wrap_negative <= cfg_wdata[0];
                REG_ONE_WAY_DEPTH: cfg_reg.one_way_depth <= cfg_wdata[0];
                REG_DEPTH_LEVELS:  cfg_reg.depth_levels  <= cfg_wdata[LEVELS_W-1:0];
                REG_INVERT_OUTPUT: cfg_reg.invert_output <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Row end and byte boundary at acceptance
    always_comb
    begin
        if (cfg_reg.row_width == '0)
        begin
            row_eff = ROW_W'(1);
        end
        else if ({{(32-ROW_W){1'b0}}, cfg_reg.row_width} > MAX_ROW_WIDTH)
        begin
            row_eff = ROW_W'(MAX_ROW_WIDTH);
        end
        else
        begin
            row_eff = cfg_reg.row_width;
        end
        end_now  = (ROW_W'(col_reg) + ROW_W'(1)) >= row_eff;
        emit_now = (col_reg[2:0] == 3'd7) || end_now;
    end

    assign s1_fire       = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        col_next = col_reg;
        if (pix_acc)
        begin
            col_next = end_now ? '0 : col_reg + COL_W'(1);
        end

        s1_valid_next = s1_valid_reg;
        if (pix_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Stores: read at acceptance, line write when the column retires
    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            pat_mem[in_pat_idx[PAT_W-1:0]] <= in_pat_pix;
        end
        if (pix_acc && !src.use_line)
        begin
            pat_rd_reg <= pat_mem[src.pat_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_mem[s1_col_reg] <= pix;
        end
        if (pix_acc && src.use_line)
        begin
            line_rd_reg <= line_mem[src.line_idx];
        end
    end

    // Pixel choice with forward of the last line write
    always_comb
    begin
        if (!s1_use_line_reg)
        begin
            pix = pat_rd_reg;
        end
        else if (lw_valid_reg && (lw_addr_reg == s1_line_idx_reg))
        begin
            pix = lw_data_reg;
        end
        else
        begin
            pix = line_rd_reg;
        end

        acc_set = acc_reg;
        acc_set[3'd7 - s1_col_reg[2:0]] = pix ^ cfg_reg.invert_output;

        acc_next = acc_reg;
        if (s1_fire)
        begin
            acc_next = s1_emit_reg ? '0 : acc_set;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_emit_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            s1_valid_reg  <= s1_valid_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_use_line_reg <= src.use_line;
            s1_line_idx_reg <= src.line_idx;
            s1_col_reg      <= col_reg;
            s1_emit_reg     <= emit_now;
            s1_end_reg      <= end_now;
        end
        if (s1_fire)
        begin
            lw_addr_reg <= s1_col_reg;
            lw_data_reg <= pix;
        end
        if (s1_fire && s1_emit_reg)
        begin
            out_byte_reg <= acc_set;
            out_last_reg <= s1_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
